// File: src/tked_pkg.sv
// Shared types and constants of the terminal key event decoder.
package tked_pkg;

    // Kinds of key event.
    typedef enum logic [2:0] {
        KIND_LETTER    = 3'd0,
        KIND_RETURN    = 3'd1,
        KIND_BACKSPACE = 3'd2,
        KIND_TAB       = 3'd3,
        KIND_CTRL      = 3'd4,
        KIND_LONE_ESC  = 3'd5,
        KIND_ARROW     = 3'd6,
        KIND_OTHER     = 3'd7
    } key_kind_t;

    // One key event as it leaves the block; raw[0] is the first raw byte.
    typedef struct packed {
        key_kind_t       kind;
        logic [2:0]      len;
        logic [3:0][7:0] raw;
        logic [1:0]      dir;
    } key_event_t;

    // A single input word gives rise to at most this many events.
    localparam int EVENTS_PER_WORD = 3;

    // Everything that one input word causes, as held in the queue.
    typedef struct packed {
        logic [1:0]                            count;
        key_event_t [EVENTS_PER_WORD-1:0]      ev;
    } event_bundle_t;

    // Byte codes.
    localparam logic [7:0] BYTE_TAB      = 8'd9;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_ESC      = 8'd27;
    localparam logic [7:0] BYTE_CTRL_MAX = 8'd26;
    localparam logic [7:0] BYTE_PRINT_LO = 8'd32;
    localparam logic [7:0] BYTE_DEL      = 8'd127;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
    localparam logic [7:0] BYTE_UPPER_A  = 8'h41;
    localparam logic [7:0] BYTE_UPPER_D  = 8'h44;

    // Continuation bytes still to come after a UTF-8 starter, by bits 5:4.
    localparam logic [1:0] UTF8_EXTRA [4] = '{2'd1, 2'd1, 2'd2, 2'd3};

endpackage

// File: src/tked_front.sv
// Front end: byte parser that turns each accepted word into a bundle of events.
module tked_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              in_byte,
    input  logic                    chunk_end,
    output tked_pkg::event_bundle_t bundle
);

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_UTF8 = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_ESC2 = 4'b1000
    } parse_mode_t;

    typedef struct packed {
        parse_mode_t     mode;
        logic [1:0]      needed;
        logic [1:0]      count;
        logic [2:0][7:0] held;
    } pstate_t;

    typedef struct packed {
        logic [1:0]                  n;
        tked_pkg::key_event_t [1:0]  ev;
        pstate_t                     st;
    } step_res_t;

    parse_mode_t     mode_reg, mode_next;
    logic [1:0]      needed_reg, needed_next;
    logic [1:0]      count_reg, count_next;
    logic [2:0][7:0] held_reg, held_next;

    pstate_t    s_cur;
    pstate_t    s_idle;
    step_res_t  r_main;
    step_res_t  r_first;
    step_res_t  r_second;
    logic       is_arrow;
    logic [7:0] arrow_off;
    tked_pkg::key_event_t arrow_ev;

    function automatic tked_pkg::key_event_t single_event(tked_pkg::key_kind_t k,
                                                          logic [7:0] b);
        tked_pkg::key_event_t e;
        e        = '0;
        e.kind   = k;
        e.len    = 3'd1;
        e.raw[0] = b;
        return e;
    endfunction

    function automatic tked_pkg::key_kind_t ascii_kind(logic [7:0] b);
        tked_pkg::key_kind_t k;
        if (b >= tked_pkg::BYTE_PRINT_LO && b < tked_pkg::BYTE_DEL)
            k = tked_pkg::KIND_LETTER;
        else if (b == tked_pkg::BYTE_CR)
            k = tked_pkg::KIND_RETURN;
        else if (b == tked_pkg::BYTE_DEL)
            k = tked_pkg::KIND_BACKSPACE;
        else if (b == tked_pkg::BYTE_TAB)
            k = tked_pkg::KIND_TAB;
        else if (b != 8'd0 && b <= tked_pkg::BYTE_CTRL_MAX)
            k = tked_pkg::KIND_CTRL;
        else
            k = tked_pkg::KIND_OTHER;
        return k;
    endfunction

    // A byte seen with the parser idle gives at most one event.
    function automatic step_res_t feed_idle(pstate_t s, logic [7:0] b, logic end_flag);
        step_res_t r;
        r         = '0;
        r.st      = s;
        r.st.mode = MODE_IDLE;
        if (b == tked_pkg::BYTE_ESC) begin
            if (end_flag) begin
                r.n     = 2'd1;
                r.ev[0] = single_event(tked_pkg::KIND_LONE_ESC, tked_pkg::BYTE_ESC);
            end
            else begin
                r.st.held[0] = tked_pkg::BYTE_ESC;
                r.st.count   = 2'd1;
                r.st.mode    = MODE_ESC;
            end
        end
        else if (!b[7]) begin
            r.n     = 2'd1;
            r.ev[0] = single_event(ascii_kind(b), b);
        end
        else if (b[6]) begin
            r.st.held[0] = b;
            r.st.count   = 2'd1;
            r.st.needed  = tked_pkg::UTF8_EXTRA[b[5:4]];
            r.st.mode    = MODE_UTF8;
        end
        return r;
    endfunction

    // One byte in any mode but the one after ESC and a byte; up to two events.
    function automatic step_res_t feed_basic(pstate_t s, logic [7:0] b, logic end_flag);
        step_res_t            r;
        step_res_t            ri;
        pstate_t              si;
        tked_pkg::key_event_t le;
        r    = '0;
        r.st = s;
        si   = s;
        si.mode  = MODE_IDLE;
        si.count = 2'd0;
        ri = feed_idle(si, b, end_flag);
        le = '0;
        unique case (s.mode)
            MODE_IDLE: begin
                r = feed_idle(s, b, end_flag);
            end
            MODE_UTF8: begin
                if (s.needed <= 2'd1 || s.count == 2'd3) begin
                    le.kind = tked_pkg::KIND_LETTER;
                    le.len  = {1'b0, s.count} + 3'd1;
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(s.count))
                            le.raw[k] = s.held[k];
                    end
                    le.raw[s.count] = b;
                    r.n       = 2'd1;
                    r.ev[0]   = le;
                    r.st.mode   = MODE_IDLE;
                    r.st.count  = 2'd0;
                    r.st.needed = 2'd0;
                end
                else begin
                    r.st.held[s.count] = b;
                    r.st.count  = s.count + 2'd1;
                    r.st.needed = s.needed - 2'd1;
                end
            end
            MODE_ESC: begin
                if (end_flag) begin
                    r       = ri;
                    r.ev[1] = ri.ev[0];
                    r.ev[0] = single_event(tked_pkg::KIND_LONE_ESC, tked_pkg::BYTE_ESC);
                    r.n     = ri.n + 2'd1;
                end
                else begin
                    r.st.held[1] = b;
                    r.st.count   = 2'd2;
                    r.st.mode    = MODE_ESC2;
                end
            end
            default: begin
                r.n = 2'd0;
            end
        endcase
        return r;
    endfunction

    assign s_cur = '{mode: mode_reg, needed: needed_reg, count: count_reg, held: held_reg};

    always_comb
    begin
        s_idle       = s_cur;
        s_idle.mode  = MODE_IDLE;
        s_idle.count = 2'd0;

        arrow_off = in_byte - tked_pkg::BYTE_UPPER_A;
        is_arrow  = (held_reg[1] == tked_pkg::BYTE_LBRACKET) &&
                    (in_byte >= tked_pkg::BYTE_UPPER_A) &&
                    (in_byte <= tked_pkg::BYTE_UPPER_D);
        arrow_ev        = '0;
        arrow_ev.kind   = tked_pkg::KIND_ARROW;
        arrow_ev.len    = 3'd3;
        arrow_ev.raw[0] = tked_pkg::BYTE_ESC;
        arrow_ev.raw[1] = tked_pkg::BYTE_LBRACKET;
        arrow_ev.raw[2] = in_byte;
        arrow_ev.dir    = arrow_off[1:0];

        r_main   = feed_basic(s_cur, in_byte, chunk_end);
        // A failed escape sequence: the held byte is parsed again, then this one.
        r_first  = feed_idle(s_idle, held_reg[1], 1'b0);
        r_second = feed_basic(r_first.st, in_byte, chunk_end);

        bundle = '0;
        if (mode_reg == MODE_ESC2) begin
            if (is_arrow) begin
                bundle.count = 2'd1;
                bundle.ev[0] = arrow_ev;
                mode_next    = MODE_IDLE;
                needed_next  = needed_reg;
                count_next   = 2'd0;
                held_next    = held_reg;
            end
            else begin
                bundle.count = 2'd1 + r_first.n + r_second.n;
                bundle.ev[0] = single_event(tked_pkg::KIND_OTHER, tked_pkg::BYTE_ESC);
                bundle.ev[1] = (r_first.n != 2'd0) ? r_first.ev[0] : r_second.ev[0];
                bundle.ev[2] = (r_first.n != 2'd0) ? r_second.ev[0] : r_second.ev[1];
                mode_next    = r_second.st.mode;
                needed_next  = r_second.st.needed;
                count_next   = r_second.st.count;
                held_next    = r_second.st.held;
            end
        end
        else begin
            bundle.count = r_main.n;
            bundle.ev[0] = r_main.ev[0];
            bundle.ev[1] = r_main.ev[1];
            mode_next    = r_main.st.mode;
            needed_next  = r_main.st.needed;
            count_next   = r_main.st.count;
            held_next    = r_main.st.held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            needed_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else if (accept) begin
            mode_reg   <= mode_next;
            needed_reg <= needed_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

// File: src/tked_queue.sv
// Short queue of event bundles between the parser and the emitter.
module tked_queue #(
    parameter int DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tked_pkg::event_bundle_t push_data,
    input  logic                    pop,
    output logic                    full,
    output logic                    not_empty,
    output tked_pkg::event_bundle_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tked_pkg::event_bundle_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/tked_back.sv
// Back end: emits the events of each queued bundle into the output register, one per cycle unless out_stall holds it.
module tked_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  tked_pkg::event_bundle_t head,
    input  logic                    out_stall,
    output logic                    pop,
    output logic                    out_valid,
    output tked_pkg::key_event_t    out_ev,
    output logic                    out_last
);

    logic [1:0]           idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    tked_pkg::key_event_t out_ev_reg;
    logic                 out_last_reg;
    logic                 load;
    logic                 is_last;

    assign load    = q_valid && (!out_valid_reg || !out_stall);
    assign is_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load) begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_ev_reg   <= head.ev[idx_reg];
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;

endmodule

// File: src/terminal_key_event_decoder_unit.sv
// An accepted word's first event is held in the bundle queue, then in the output register.
// Throughput: one input word per cycle while each word yields at most one event and the
// output is not stalled; a word's events leave one by one via the single output register.
// The bundle queue (QUEUE_DEPTH words) lets input continue while events wait downstream.
// Reset is asynchronous and active low; it clears the parser mode and counts, the queue
// pointers and the output valid flag; held bytes and payload registers are not reset.
module terminal_key_event_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       chunk_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [2:0] key_len,
    output logic [7:0] raw_first,
    output logic [7:0] raw_second,
    output logic [7:0] raw_third,
    output logic [7:0] raw_fourth,
    output logic [1:0] arrow_dir,
    output logic       last_result
);

    // The front end parses one byte per accepted word and produces a bundle of
    // up to three events, together with the next parser state.  A word that
    // produces no event (a stray continuation byte, or a byte held for a
    // UTF-8 letter or an escape sequence) updates the parser and nothing else.
    tked_pkg::event_bundle_t bundle;
    tked_pkg::event_bundle_t head;
    tked_pkg::key_event_t    out_ev;

    logic accept;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    logic out_last;

    // The input side stalls only when the queue is full, so the front end
    // never waits on the output handshake directly.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (bundle.count != 2'd0);

    tked_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .chunk_end (chunk_end),
        .bundle    (bundle)
    );

    tked_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    // The back end walks through the head bundle, one event per cycle while the output is
    // not stalled, and marks the final event of each word as the last result.
    tked_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ev    (out_ev),
        .out_last  (out_last)
    );

    assign kind        = out_ev.kind;
    assign key_len     = out_ev.len;
    assign raw_first   = out_ev.raw[0];
    assign raw_second  = out_ev.raw[1];
    assign raw_third   = out_ev.raw[2];
    assign raw_fourth  = out_ev.raw[3];
    assign arrow_dir   = out_ev.dir;
    assign last_result = out_last;

endmodule

// File: src/tked_checker.sv
// Port-level checker for the terminal key event decoder, with its bind statement.
module tked_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       chunk_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [2:0] key_len,
    input logic [7:0] raw_first,
    input logic [7:0] raw_second,
    input logic [7:0] raw_third,
    input logic [7:0] raw_fourth,
    input logic [1:0] arrow_dir,
    input logic       last_result
);

    // A stalled output word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(raw_first) &&
                                   $stable(last_result))
    else $error("stalled output word changed");

    // Only arrow events carry a direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != tked_pkg::KIND_ARROW |-> arrow_dir == 2'd0)
    else $error("direction set on a non-arrow event");

    // An arrow event is always ESC, '[' and a letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tked_pkg::KIND_ARROW |->
            key_len == 3'd3 && raw_first == tked_pkg::BYTE_ESC &&
            raw_second == tked_pkg::BYTE_LBRACKET && raw_fourth == 8'd0)
    else $error("malformed arrow event");

    // Single-byte events leave the other raw bytes clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_len == 3'd1 |->
            raw_second == 8'd0 && raw_third == 8'd0 && raw_fourth == 8'd0)
    else $error("unused raw bytes not clear");

endmodule

bind terminal_key_event_decoder_unit tked_checker u_tked_checker (.*);

// File: tb/sv/tked_event_checker.sv
// Checker that predicts the key events of the decoder and compares them with its output.
`timescale 1ns / 1ps

module tked_event_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       chunk_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] kind,
    input  logic [2:0] key_len,
    input  logic [7:0] raw_first,
    input  logic [7:0] raw_second,
    input  logic [7:0] raw_third,
    input  logic [7:0] raw_fourth,
    input  logic [1:0] arrow_dir,
    input  logic       last_result,
    output int         fail_count,
    output int         pending_count,
    output int         checked_count
);

    typedef enum logic [1:0] {
        PARSE_IDLE    = 2'd0,
        PARSE_UTF8    = 2'd1,
        PARSE_ESC     = 2'd2,
        PARSE_ESC_ARG = 2'd3
    } parse_mode_t;

    typedef struct packed {
        tked_pkg::key_event_t ev;
        logic                 last;
    } expected_event_t;

    // Private copy of the parser state.
    parse_mode_t     mode = PARSE_IDLE;
    logic [1:0]      need = 2'd0;
    logic [1:0]      held_n = 2'd0;
    logic [7:0]      held [3];

    tked_pkg::key_event_t word_events [$];
    expected_event_t      expected_q [$];
    int                   fails = 0;
    int                   checks = 0;

    function automatic void add_event(tked_pkg::key_kind_t k, logic [2:0] n,
                                      logic [3:0][7:0] raw, logic [1:0] d);
        tked_pkg::key_event_t ev;
        if (word_events.size() < tked_pkg::EVENTS_PER_WORD)
        begin
            ev.kind = k;
            ev.len  = n;
            ev.raw  = raw;
            ev.dir  = d;
            word_events.push_back(ev);
        end
    endfunction

    function automatic tked_pkg::key_kind_t ascii_kind(logic [7:0] b);
        if (b >= tked_pkg::BYTE_PRINT_LO && b < tked_pkg::BYTE_DEL)
            return tked_pkg::KIND_LETTER;
        else if (b == tked_pkg::BYTE_CR)
            return tked_pkg::KIND_RETURN;
        else if (b == tked_pkg::BYTE_DEL)
            return tked_pkg::KIND_BACKSPACE;
        else if (b == tked_pkg::BYTE_TAB)
            return tked_pkg::KIND_TAB;
        else if (b != 8'd0 && b <= tked_pkg::BYTE_CTRL_MAX)
            return tked_pkg::KIND_CTRL;
        return tked_pkg::KIND_OTHER;
    endfunction

    // Works out the events of one accepted word. Bytes that the parser has to look at
    // again are put back at the head of a small work list, so no recursion is needed.
    function automatic void predict_word(logic [7:0] in_b, logic in_end);
        logic [8:0]      pend [$];
        logic [7:0]      b;
        logic            last;
        logic [7:0]      x;
        logic [3:0][7:0] raw;
        expected_event_t exp_ev;
        word_events.delete();
        pend.push_back({in_end, in_b});
        while (pend.size() > 0)
        begin
            {last, b} = pend.pop_front();
            case (mode)
                PARSE_IDLE:
                begin
                    if (b == tked_pkg::BYTE_ESC)
                    begin
                        if (last)
                            add_event(tked_pkg::KIND_LONE_ESC, 3'd1,
                                      {24'd0, tked_pkg::BYTE_ESC}, 2'd0);
                        else
                        begin
                            held[0] = tked_pkg::BYTE_ESC;
                            held_n  = 2'd1;
                            mode    = PARSE_ESC;
                        end
                    end
                    else if (!b[7])
                        add_event(ascii_kind(b), 3'd1, {24'd0, b}, 2'd0);
                    else if (b[6])
                    begin
                        held[0] = b;
                        held_n  = 2'd1;
                        need    = (b[5:4] == 2'b11) ? 2'd3 : (b[5:4] == 2'b10) ? 2'd2 : 2'd1;
                        mode    = PARSE_UTF8;
                    end
                    // A stray continuation byte is dropped without an event.
                end
                PARSE_UTF8:
                begin
                    if (need <= 2'd1 || held_n >= 2'd3)
                    begin
                        raw = '0;
                        for (int k = 0; k < 3; k++)
                            if (k < held_n)
                                raw[k] = held[k];
                        raw[held_n] = b;
                        add_event(tked_pkg::KIND_LETTER, {1'b0, held_n} + 3'd1, raw, 2'd0);
                        mode   = PARSE_IDLE;
                        held_n = 2'd0;
                        need   = 2'd0;
                    end
                    else
                    begin
                        held[held_n] = b;
                        held_n++;
                        need--;
                    end
                end
                PARSE_ESC:
                begin
                    if (last)
                    begin
                        add_event(tked_pkg::KIND_LONE_ESC, 3'd1,
                                  {24'd0, tked_pkg::BYTE_ESC}, 2'd0);
                        mode   = PARSE_IDLE;
                        held_n = 2'd0;
                        pend.push_front({1'b1, b});
                    end
                    else
                    begin
                        held[1] = b;
                        held_n  = 2'd2;
                        mode    = PARSE_ESC_ARG;
                    end
                end
                PARSE_ESC_ARG:
                begin
                    x      = held[1];
                    mode   = PARSE_IDLE;
                    held_n = 2'd0;
                    if (x == tked_pkg::BYTE_LBRACKET && b >= tked_pkg::BYTE_UPPER_A &&
                        b <= tked_pkg::BYTE_UPPER_D)
                        add_event(tked_pkg::KIND_ARROW, 3'd3,
                                  {8'd0, b, tked_pkg::BYTE_LBRACKET, tked_pkg::BYTE_ESC},
                                  2'(b - tked_pkg::BYTE_UPPER_A));
                    else
                    begin
                        // The held byte is seen again as mid-chunk, then this one.
                        add_event(tked_pkg::KIND_OTHER, 3'd1,
                                  {24'd0, tked_pkg::BYTE_ESC}, 2'd0);
                        pend.push_front({last, b});
                        pend.push_front({1'b0, x});
                    end
                end
            endcase
        end
        for (int i = 0; i < word_events.size(); i++)
        begin
            exp_ev.ev   = word_events[i];
            exp_ev.last = (i == word_events.size() - 1);
            expected_q.push_back(exp_ev);
        end
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        expected_event_t head;
        if (!rst_n)
        begin
            mode   = PARSE_IDLE;
            need   = 2'd0;
            held_n = 2'd0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("Event with no prediction waiting: kind %0d, raw_first 0x%02h",
                           kind, raw_first);
                    fails++;
                end
                else
                begin
                    head = expected_q.pop_front();
                    compare_field("kind", head.ev.kind, kind);
                    compare_field("key_len", head.ev.len, key_len);
                    compare_field("raw_first", head.ev.raw[0], raw_first);
                    compare_field("raw_second", head.ev.raw[1], raw_second);
                    compare_field("raw_third", head.ev.raw[2], raw_third);
                    compare_field("raw_fourth", head.ev.raw[3], raw_fourth);
                    compare_field("arrow_dir", head.ev.dir, arrow_dir);
                    compare_field("last_result", head.last, last_result);
                    checks++;
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_byte, chunk_end);
        end
        fail_count    <= fails;
        pending_count <= expected_q.size();
        checked_count <= checks;
    end

endmodule

// File: tb/sv/tb_terminal_key_event_decoder_unit.sv
// Top of the testbench for the terminal key event decoder: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_terminal_key_event_decoder_unit;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 7;
    // The longest run of idle cycles on either side; this bounds the quiet stretches
    // that the watchdog must tolerate.
    localparam int MAX_IDLE_RUN     = 20;
    localparam int WATCHDOG_LIMIT   = 500;
    // These cycles, waited after the last pending event, give any stray event a chance
    // to show itself before the verdict.
    localparam int DRAIN_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 98;

    // Idling phases of the random part: no idling, sender idle, receiver stalling, both.
    localparam int PHASE_IDLE_PCT  [4] = '{0, 67, 0, 12};
    localparam int PHASE_STALL_PCT [4] = '{0, 0, 67, 12};

    // Directed words, {chunk_end, in_byte}.
    localparam logic [8:0] DIRECTED_WORDS [29] = '{
        // Single-byte classes: NUL, tab, return, delete, space, Ctrl-A, Ctrl-Z, a 28..31 code.
        9'h000, 9'h009, 9'h00D, 9'h07F, 9'h020, 9'h001, 9'h01A, 9'h01C,
        // A stray continuation byte with the top bit pattern 10.
        9'h080,
        // An escape that ends its chunk on its own.
        9'h11B,
        // Arrow up, then arrow left closing a chunk.
        9'h01B, 9'h05B, 9'h041, 9'h01B, 9'h05B, 9'h144,
        // An escape with only one byte after it before the chunk ends.
        9'h01B, 9'h141,
        // A failed escape whose last byte is a four-byte starter; that letter then
        // swallows an escape and a newline and spans a chunk end.
        9'h01B, 9'h078, 9'h1FF, 9'h080, 9'h01B, 9'h10A,
        // Three escapes in a row give three events from the last word.
        9'h01B, 9'h01B, 9'h11B,
        // A two-byte letter split across chunks.
        9'h1C3, 9'h0A9
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       chunk_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [2:0] key_len;
    logic [7:0] raw_first;
    logic [7:0] raw_second;
    logic [7:0] raw_third;
    logic [7:0] raw_fourth;
    logic [1:0] arrow_dir;
    logic       last_result;

    int fail_count;
    int pending_count;
    int checked_count;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_run = 0;
    int idle_cycles = 0;
    int words_sent = 0;
    int ignored_words = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    terminal_key_event_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .chunk_end   (chunk_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .key_len     (key_len),
        .raw_first   (raw_first),
        .raw_second  (raw_second),
        .raw_third   (raw_third),
        .raw_fourth  (raw_fourth),
        .arrow_dir   (arrow_dir),
        .last_result (last_result)
    );

    // The checker sits beside the block, watching both channels; it owns the
    // prediction and hands back its counts.
    tked_event_checker u_event_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .chunk_end     (chunk_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .key_len       (key_len),
        .raw_first     (raw_first),
        .raw_second    (raw_second),
        .raw_third     (raw_third),
        .raw_fourth    (raw_fourth),
        .arrow_dir     (arrow_dir),
        .last_result   (last_result),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    function automatic logic chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // The receiver stalls cycle by cycle at the rate of the current phase. A run of
    // stalls is cut short at its limit so that the output is never blocked for good.
    always @(posedge clk)
    begin
        if (stall_run < MAX_IDLE_RUN && chance(recv_stall_pct))
        begin
            out_stall <= 1'b1;
            stall_run++;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
    end

    // The watchdog counts cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offers one word and returns at the edge where it is taken. The sender may first
    // sit idle for some cycles; the payload holds still while the block stalls it.
    // A word that follows directly keeps valid high, so valid is never dropped and
    // raised within one time step.
    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = 0;
        while (gap < MAX_IDLE_RUN && chance(sender_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        chunk_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // One random key sequence. Most are well formed (letters, complete UTF-8 runs,
    // arrows) so that the parser travels through all its modes; the rest are broken
    // escapes, lone escapes, stray continuation bytes and plain noise. Chunk ends fall
    // at random, including in the middle of a sequence.
    task automatic send_random_sequence();
        int         pick;
        int         extra;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 30)
            send_word(8'($urandom_range(127)), chance(25));
        else if (pick < 50)
        begin
            lead  = 8'($urandom_range(8'hFF, 8'hC0));
            extra = (lead[5:4] == 2'b11) ? 3 : (lead[5:4] == 2'b10) ? 2 : 1;
            send_word(lead, chance(20));
            repeat (extra)
                send_word(chance(85) ? 8'($urandom_range(8'hBF, 8'h80)) : 8'($urandom),
                          chance(20));
        end
        else if (pick < 65)
        begin
            send_word(tked_pkg::BYTE_ESC, 1'b0);
            send_word(tked_pkg::BYTE_LBRACKET, chance(5));
            send_word(8'(tked_pkg::BYTE_UPPER_A + $urandom_range(3)), chance(40));
        end
        else if (pick < 77)
        begin
            send_word(tked_pkg::BYTE_ESC, chance(15));
            send_word(8'($urandom), chance(25));
            send_word(8'($urandom), chance(30));
        end
        else if (pick < 84)
        begin
            send_word(tked_pkg::BYTE_ESC, chance(50));
            if (chance(50))
                send_word(8'($urandom), 1'b1);
        end
        else if (pick < 90)
        begin
            // Usually dropped by the block, so it does not count towards the total.
            send_word(8'($urandom_range(8'hBF, 8'h80)), chance(25));
            ignored_words++;
        end
        else
            send_word(8'($urandom), chance(25));
    endtask

    initial
    begin : stimulus
        int target;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed words run without any idling.
        foreach (DIRECTED_WORDS[i])
            send_word(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][8]);

        // The phases follow one another without a pause.
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct <= PHASE_IDLE_PCT[p];
            recv_stall_pct  <= PHASE_STALL_PCT[p];
            target = words_sent - ignored_words + RANDOM_PER_PHASE;
            while (words_sent - ignored_words < target)
                send_random_sequence();
        end
        in_valid <= 1'b0;

        // One edge first, so that the count of pending events includes the last word.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d input words (%0d directed) over four idling phases.",
                 words_sent, $size(DIRECTED_WORDS));
        $display("%0d key events were compared, with %0d failures.",
                 checked_count, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
